@@ rtl/core/calendar_clock_step_core_defines.svh @@
// assertion macros for the calendar clock core
// depends on: nothing; users provide clk_i and rst_ni in scope
`ifndef CALENDAR_CLOCK_STEP_CORE_DEFINES_SVH
`define CALENDAR_CLOCK_STEP_CORE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define CCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ccs_pkg.sv @@
// shared types, constants and calendar helpers for the calendar clock core
// depends on: nothing
package ccs_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  localparam logic [YEAR_W-1:0]  YEAR_TOP  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_LAST  = DAY_W'(31);
  localparam logic [DAY_W-1:0]   FEB_LEAP  = DAY_W'(29);
  localparam logic [HOUR_W-1:0]  HOUR_TOP  = HOUR_W'(23);
  localparam logic [MIN_W-1:0]   MIN_TOP   = MIN_W'(59);
  localparam logic [SEC_W-1:0]   SEC_TOP   = SEC_W'(59);

  // year / 100 as (year * 5243) >> 19, exact for any 14-bit year
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV100_Q_W   = 8;
  localparam int unsigned DIV100_P_W   = DIV100_SHIFT + DIV100_Q_W;
  localparam logic [DIV100_P_W-1:0] DIV100_RECIP = DIV100_P_W'(5243);

  // indexed by month directly, unused codes read zero
  localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
    DAY_W'(0),  DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31),
    DAY_W'(30), DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
    DAY_W'(31), DAY_W'(0),  DAY_W'(0),  DAY_W'(0)
  };

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FWD  = 2'd0,
    FUNC_BACK = 2'd1,
    FUNC_LOAD = 2'd2
  } ccs_func_e;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } ccs_time_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    ccs_time_t         load;
    logic              load_leap;
  } ccs_req_t;

  function automatic logic ccs_leap(input logic [YEAR_W-1:0] y);
    logic [DIV100_P_W-1:0] prod;
    logic [DIV100_Q_W-1:0] q;
    logic [YEAR_W:0]       q100;
    logic                  div100;
    prod   = DIV100_P_W'(y) * DIV100_RECIP;
    q      = prod[DIV100_SHIFT +: DIV100_Q_W];
    // q * 100 = q*64 + q*32 + q*4
    q100   = (YEAR_W+1)'({q, 6'b0}) + (YEAR_W+1)'({q, 5'b0}) + (YEAR_W+1)'({q, 2'b0});
    div100 = (q100 == {1'b0, y});
    return (y[1:0] == 2'b00) && (!div100 || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] ccs_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    if ((m == MONTH_FEB) && leap) begin
      return FEB_LEAP;
    end
    return MONTH_LEN[m];
  endfunction

endpackage

@@ rtl/core/ccs_req_if.sv @@
// request channel of the calendar clock core: command and load fields
// depends on: ccs_pkg
interface ccs_req_if import ccs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [YEAR_W-1:0]  load_year;
  logic [MONTH_W-1:0] load_month;
  logic [DAY_W-1:0]   load_day;
  logic [HOUR_W-1:0]  load_hour;
  logic [MIN_W-1:0]   load_minute;
  logic [SEC_W-1:0]   load_second;

  modport source(output valid, func, load_year, load_month, load_day, load_hour,
                 load_minute, load_second, input ready);
  modport sink(input valid, func, load_year, load_month, load_day, load_hour,
               load_minute, load_second, output ready);
endinterface

@@ rtl/core/ccs_rsp_if.sv @@
// response channel of the calendar clock core: current date and time
// depends on: ccs_pkg
interface ccs_rsp_if import ccs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  cur_year;
  logic [MONTH_W-1:0] cur_month;
  logic [DAY_W-1:0]   cur_day;
  logic [HOUR_W-1:0]  cur_hour;
  logic [MIN_W-1:0]   cur_minute;
  logic [SEC_W-1:0]   cur_second;

  modport source(output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute,
                 cur_second, input ready);
  modport sink(input valid, cur_year, cur_month, cur_day, cur_hour, cur_minute,
               cur_second, output ready);
endinterface

@@ rtl/core/ccs_in_reg.sv @@
// input register of the calendar clock core, with leap flag of the load year
// depends on: ccs_pkg, ccs_req_if
module ccs_in_reg import ccs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccs_req_if.sink   req_i,
  input  logic      pop_i,
  output logic      vld_o,
  output ccs_req_t  req_o
);

  logic     vld_q, vld_d;
  ccs_req_t req_q, req_d;
  logic     take;

  assign req_i.ready = !vld_q || pop_i;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    vld_d = vld_q;
    req_d = req_q;
    if (take) begin
      vld_d               = 1'b1;
      req_d.func          = req_i.func;
      req_d.load.year     = req_i.load_year;
      req_d.load.month    = req_i.load_month;
      req_d.load.day      = req_i.load_day;
      req_d.load.hour     = req_i.load_hour;
      req_d.load.minute   = req_i.load_minute;
      req_d.load.second   = req_i.load_second;
      req_d.load_leap     = ccs_leap(req_i.load_year);
    end else if (pop_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign vld_o = vld_q;
  assign req_o = req_q;

endmodule

@@ rtl/core/ccs_step.sv @@
// next date and time for one request: one-second step forward or back, or load
// depends on: ccs_pkg
module ccs_step import ccs_pkg::*; (
  input  ccs_req_t  req_i,
  input  ccs_time_t cur_i,
  input  logic      leap_i,
  output ccs_time_t nxt_o
);

  logic [DAY_W-1:0]   len;
  logic [DAY_W-1:0]   prev_len;
  logic [MONTH_W-1:0] prev_month;
  logic               month_ok;

  assign month_ok   = (cur_i.month >= MONTH_JAN) && (cur_i.month <= MONTH_DEC);
  assign prev_month = cur_i.month - MONTH_W'(1);
  assign len        = ccs_month_len(cur_i.month, leap_i);
  assign prev_len   = ccs_month_len(prev_month, leap_i);

  always_comb begin
    nxt_o = cur_i;
    unique case (ccs_func_e'(req_i.func))
      FUNC_FWD: begin
        if (cur_i.second != SEC_TOP) begin
          nxt_o.second = cur_i.second + SEC_W'(1);
        end else if (cur_i.minute != MIN_TOP) begin
          nxt_o.second = '0;
          nxt_o.minute = cur_i.minute + MIN_W'(1);
        end else if (cur_i.hour != HOUR_TOP) begin
          nxt_o.second = '0;
          nxt_o.minute = '0;
          nxt_o.hour   = cur_i.hour + HOUR_W'(1);
        end else begin
          nxt_o.second = '0;
          nxt_o.minute = '0;
          nxt_o.hour   = '0;
          // a day past the month length leaves the date alone
          if (month_ok) begin
            if (cur_i.day < len) begin
              nxt_o.day = cur_i.day + DAY_W'(1);
            end else if (cur_i.day == len) begin
              nxt_o.day = DAY_FIRST;
              if (cur_i.month == MONTH_DEC) begin
                nxt_o.month = MONTH_JAN;
                nxt_o.year  = (cur_i.year >= YEAR_TOP) ? '0 : cur_i.year + YEAR_W'(1);
              end else begin
                nxt_o.month = cur_i.month + MONTH_W'(1);
              end
            end
          end
        end
      end
      FUNC_BACK: begin
        if (cur_i.second != '0) begin
          nxt_o.second = cur_i.second - SEC_W'(1);
        end else if (cur_i.minute != '0) begin
          nxt_o.second = SEC_TOP;
          nxt_o.minute = cur_i.minute - MIN_W'(1);
        end else if (cur_i.hour != '0) begin
          nxt_o.second = SEC_TOP;
          nxt_o.minute = MIN_TOP;
          nxt_o.hour   = cur_i.hour - HOUR_W'(1);
        end else begin
          nxt_o.second = SEC_TOP;
          nxt_o.minute = MIN_TOP;
          nxt_o.hour   = HOUR_TOP;
          // day zero leaves the date alone
          if (month_ok) begin
            if (cur_i.day > DAY_FIRST) begin
              nxt_o.day = cur_i.day - DAY_W'(1);
            end else if (cur_i.day == DAY_FIRST) begin
              if (cur_i.month == MONTH_JAN) begin
                nxt_o.year  = (cur_i.year == '0) ? YEAR_TOP : cur_i.year - YEAR_W'(1);
                nxt_o.month = MONTH_DEC;
                nxt_o.day   = DAY_LAST;
              end else begin
                nxt_o.month = prev_month;
                nxt_o.day   = prev_len;
              end
            end
          end
        end
      end
      FUNC_LOAD: begin
        nxt_o = req_i.load;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

@@ rtl/core/calendar_clock_step_core.sv @@
// top level of the calendar clock core: input register, step logic, time register
// depends on: ccs_pkg, ccs_req_if, ccs_rsp_if, ccs_in_reg, ccs_step, defines header
//
// Usage:
//   req_i carries one request per valid/ready handshake: func selects a step
//   forward one second, a step back one second, or a load of all six load_
//   fields (stored unchecked). An unused func code leaves the time unchanged.
//   rsp_o returns exactly one response per request, in order: the date and
//   time after that request.
//   A taken request waits in the input register until it is committed to the
//   time register, and its response is valid from then on. Throughput is one
//   request per cycle while rsp_o does not stall; the rate is set by the single
//   step of next-state logic between the input register and the time register,
//   which also serves as the response register.
//   The leap flag of the current year is kept in a register; a load sets it
//   from the load year, otherwise it follows the year in the cycle after.
//   Reset: 0000-01-01 00:00:00, no request or response pending.
//   When rsp_o stalls, the response holds, one more request can wait in the
//   input register, and req_i.ready then drops until the response is taken.
`include "calendar_clock_step_core_defines.svh"

module calendar_clock_step_core import ccs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccs_req_if.sink   req_i,
  ccs_rsp_if.source rsp_o
);

  logic      s1_vld;
  ccs_req_t  s1_req;
  logic      commit;
  logic      out_vld_q, out_vld_d;
  logic      leap_q, leap_d;
  ccs_time_t time_q, time_d;
  ccs_time_t step_nxt;

  assign commit = s1_vld && (!out_vld_q || rsp_o.ready);

  ccs_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .pop_i  (commit),
    .vld_o  (s1_vld),
    .req_o  (s1_req)
  );

  ccs_step u_step (
    .req_i  (s1_req),
    .cur_i  (time_q),
    .leap_i (leap_q),
    .nxt_o  (step_nxt)
  );

  always_comb begin
    time_d    = commit ? step_nxt : time_q;
    out_vld_d = commit ? 1'b1 : (rsp_o.ready ? 1'b0 : out_vld_q);
    // a year change by a step lands in january or december, where the
    // registered lag of the leap flag behind the year is never looked at
    if (commit && (s1_req.func == FUNC_LOAD)) begin
      leap_d = s1_req.load_leap;
    end else begin
      leap_d = ccs_leap(time_q.year);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q     <= 1'b0;
      leap_q        <= 1'b1;
      time_q.year   <= '0;
      time_q.month  <= MONTH_JAN;
      time_q.day    <= DAY_FIRST;
      time_q.hour   <= '0;
      time_q.minute <= '0;
      time_q.second <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      leap_q    <= leap_d;
      time_q    <= time_d;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.cur_year   = time_q.year;
  assign rsp_o.cur_month  = time_q.month;
  assign rsp_o.cur_day    = time_q.day;
  assign rsp_o.cur_hour   = time_q.hour;
  assign rsp_o.cur_minute = time_q.minute;
  assign rsp_o.cur_second = time_q.second;

  `CCS_ASSERT(a_leap_track,
    ((time_q.month == MONTH_JAN) || (time_q.month == MONTH_DEC) ||
     (leap_q == ccs_leap(time_q.year))),
    "leap flag does not match current year")
  `CCS_ASSERT_NEXT(a_commit_rsp, commit, out_vld_q, "committed request has no response")
  `CCS_ASSERT_NEXT(a_time_hold, !commit, $stable(time_q), "time changed without a request")
  `CCS_ASSERT_NEXT(a_sec_fwd,
    commit && (s1_req.func == FUNC_FWD) && (time_q.second < SEC_TOP),
    (time_q.second == $past(time_q.second) + SEC_W'(1)) && (time_q.minute == $past(time_q.minute)),
    "plain forward step did not advance the second")

endmodule
